// ===== rtl/dbcs_pkg.sv =====
// dbcs_pkg: shared types and constants for the code page converter.
// Used by dbcs_core, dbcs_ofifo, the top level and the bench; depends on nothing.

package dbcs_pkg;

    // request codes on the input channel
    typedef enum logic [2:0] {
        REQ_LOAD_L2U  = 3'd0,
        REQ_LOAD_U2L  = 3'd1,
        REQ_LOAD_FLAG = 3'd2,
        REQ_LOCAL     = 3'd3,
        REQ_UNI       = 3'd4
    } t_req;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_L2U_SIZE      = 3'd0,
        CFG_U2L_SIZE      = 3'd1,
        CFG_L2U_PRESENT   = 3'd2,
        CFG_U2L_PRESENT   = 3'd3,
        CFG_FLAGS_PRESENT = 3'd4
    } t_cfg_idx;

    // what the result stage does with an item
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LIT1,
        OP_LIT2,
        OP_L2U,
        OP_L2U_TERM,
        OP_U2L
    } t_op;

    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 16;
    localparam int FLAG_DEPTH = 256;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    localparam logic [15:0] CH_QMARK      = 16'h003F;
    localparam logic [15:0] CH_UNDERSCORE = 16'h005F;
    localparam logic [15:0] CH_SPACE      = 16'h0020;
    localparam logic [15:0] BYTE_MAX      = 16'h00FF;
    localparam logic [15:0] HIGH_MASK     = 16'hFF00;

    typedef struct packed {
        logic [15:0] l2u_size;
        logic [15:0] u2l_size;
        logic        l2u_present;
        logic        u2l_present;
        logic        flags_present;
    } t_cfg;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } t_res;

    // zero, one or two result words from one item
    typedef struct packed {
        logic [1:0] n;
        t_res       res0;
        t_res       res1;
    } t_push;

    typedef struct packed {
        logic s1_vld;
        logic s2_vld;
    } t_stat;

endpackage

// ===== rtl/dbcs_ram.sv =====
// dbcs_ram: generic single-port synchronous RAM with a registered read.
// Stand-alone; used for every table of the converter.

module dbcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dbcs_core.sv =====
// dbcs_core: three-step conversion pipeline around the flag and code tables.
// Depends on dbcs_pkg and dbcs_ram.

module dbcs_core #(
    parameter int L2U_DEPTH = 65536,
    parameter int U2L_DEPTH = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dbcs_pkg::t_cfg  i_cfg,
    input  logic            i_acc,
    input  logic [2:0]      i_req_type,
    input  logic [15:0]     i_table_index,
    input  logic [15:0]     i_data_word,
    output dbcs_pkg::t_push o_push,
    output dbcs_pkg::t_stat o_stat
);

    import dbcs_pkg::*;

    localparam int L2U_AW = $clog2(L2U_DEPTH);
    localparam int U2L_AW = $clog2(U2L_DEPTH);
    localparam logic [16:0] L2U_LIM = 17'(L2U_DEPTH);
    localparam logic [16:0] U2L_LIM = 17'(U2L_DEPTH);
    localparam int FLAG_AW = $clog2(FLAG_DEPTH);

    typedef struct packed {
        t_op         op;
        logic        miss;
        logic [15:0] lit0;
        logic [15:0] lit1;
    } t_s2;

    // flag table, accessed at acceptance
    logic               flag_en;
    logic               flag_we;
    logic [FLAG_AW-1:0] flag_addr;
    logic               flag_rdata;

    assign flag_we   = (i_req_type == REQ_LOAD_FLAG);
    assign flag_en   = i_acc && ((i_req_type == REQ_LOCAL) ||
                       (flag_we && (i_table_index[15:FLAG_AW] == '0)));
    assign flag_addr = flag_we ? i_table_index[FLAG_AW-1:0] : i_data_word[FLAG_AW-1:0];

    dbcs_ram #(.WIDTH(1), .DEPTH(FLAG_DEPTH)) u_flag_ram (
        .i_clk  (i_clk),
        .i_en   (flag_en),
        .i_we   (flag_we),
        .i_addr (flag_addr),
        .i_wdata(i_data_word != 16'h0000),
        .o_rdata(flag_rdata)
    );

    // stage 1 registers
    logic        r_s1_vld;
    logic [2:0]  r_s1_type;
    logic [15:0] r_s1_idx;
    logic [15:0] r_s1_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_type <= i_req_type;
            r_s1_idx  <= i_table_index;
            r_s1_data <= i_data_word;
        end
    end

    // lead byte state and stage 1 decode
    logic [7:0]  r_lead;
    logic        r_pend;
    logic [7:0]  n_lead;
    logic        n_pend;
    t_s2         n_s2;
    logic        n_s2_vld;
    logic        l2u_en;
    logic        l2u_we;
    logic [15:0] l2u_addr;
    logic [15:0] l2u_rdata;
    logic        u2l_en;
    logic        u2l_we;
    logic [15:0] u2l_rdata;

    always_comb begin
        logic [7:0]  lbyte;
        logic [15:0] code;
        logic        tbl_l;
        logic        tbl_u;
        logic        l2u_look;
        logic        l2u_miss;
        logic        u2l_miss;

        lbyte    = r_s1_data[7:0];
        tbl_l    = i_cfg.l2u_present && i_cfg.flags_present;
        tbl_u    = i_cfg.u2l_present && i_cfg.flags_present;
        code     = {8'h00, lbyte};
        l2u_look = 1'b0;
        u2l_miss = ({1'b0, r_s1_data} >= U2L_LIM) || (r_s1_data >= i_cfg.u2l_size);

        n_lead   = r_lead;
        n_pend   = r_pend;
        n_s2_vld = r_s1_vld;
        n_s2.op   = OP_NONE;
        n_s2.miss = 1'b0;
        n_s2.lit0 = 16'h0000;
        n_s2.lit1 = 16'h0000;
        u2l_en    = 1'b0;
        u2l_we    = 1'b0;
        l2u_we    = 1'b0;

        case (r_s1_type)
            REQ_LOAD_L2U: begin
                l2u_we = 1'b1;
            end
            REQ_LOAD_U2L: begin
                u2l_we = 1'b1;
                u2l_en = r_s1_vld && ({1'b0, r_s1_idx} < U2L_LIM);
            end
            REQ_LOCAL: begin
                if (lbyte == 8'h00) begin
                    // terminator: flush a held lead byte, then emit zero
                    if (r_pend) begin
                        if (tbl_l) begin
                            n_s2.op  = OP_L2U_TERM;
                            code     = {8'h00, r_lead};
                            l2u_look = 1'b1;
                        end else begin
                            n_s2.op   = OP_LIT2;
                            n_s2.lit0 = {8'h00, r_lead};
                        end
                    end else begin
                        n_s2.op = OP_LIT1;
                    end
                    n_pend = 1'b0;
                    n_lead = 8'h00;
                end else if (!tbl_l) begin
                    if (r_pend) begin
                        n_s2.op   = OP_LIT2;
                        n_s2.lit0 = {8'h00, r_lead};
                        n_s2.lit1 = {8'h00, lbyte};
                    end else begin
                        n_s2.op   = OP_LIT1;
                        n_s2.lit0 = {8'h00, lbyte};
                    end
                    n_pend = 1'b0;
                    n_lead = 8'h00;
                end else if (r_pend) begin
                    n_s2.op  = OP_L2U;
                    code     = {r_lead, lbyte};
                    l2u_look = 1'b1;
                    n_pend   = 1'b0;
                    n_lead   = 8'h00;
                end else if (!flag_rdata) begin
                    // lead byte: hold it for the trail byte
                    n_pend = 1'b1;
                    n_lead = lbyte;
                end else begin
                    n_s2.op  = OP_L2U;
                    l2u_look = 1'b1;
                end
            end
            REQ_UNI: begin
                if (r_s1_data == 16'h0000) begin
                    n_s2.op = OP_LIT1;
                end else if (!tbl_u) begin
                    n_s2.op = OP_LIT1;
                    if (r_s1_data inside {[CH_SPACE:BYTE_MAX]}) begin
                        n_s2.lit0 = r_s1_data;
                    end else begin
                        n_s2.lit0 = CH_UNDERSCORE;
                    end
                end else begin
                    n_s2.op   = OP_U2L;
                    n_s2.miss = u2l_miss;
                    u2l_en    = r_s1_vld && !u2l_miss;
                end
            end
            default: begin
                n_s2.op = OP_NONE;
            end
        endcase

        l2u_miss = ({1'b0, code} >= L2U_LIM) || (code >= i_cfg.l2u_size);
        if (l2u_look) begin
            n_s2.miss = l2u_miss;
        end
        l2u_addr = l2u_we ? r_s1_idx : code;
        l2u_en   = r_s1_vld && (l2u_we ? ({1'b0, r_s1_idx} < L2U_LIM)
                                       : (l2u_look && !l2u_miss));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 8'h00;
            r_pend <= 1'b0;
        end else if (r_s1_vld) begin
            r_lead <= n_lead;
            r_pend <= n_pend;
        end
    end

    dbcs_ram #(.WIDTH(16), .DEPTH(L2U_DEPTH)) u_l2u_ram (
        .i_clk  (i_clk),
        .i_en   (l2u_en),
        .i_we   (l2u_we),
        .i_addr (l2u_addr[L2U_AW-1:0]),
        .i_wdata(r_s1_data),
        .o_rdata(l2u_rdata)
    );

    dbcs_ram #(.WIDTH(16), .DEPTH(U2L_DEPTH)) u_u2l_ram (
        .i_clk  (i_clk),
        .i_en   (u2l_en),
        .i_we   (u2l_we),
        .i_addr (u2l_we ? r_s1_idx[U2L_AW-1:0] : r_s1_data[U2L_AW-1:0]),
        .i_wdata(r_s1_data),
        .o_rdata(u2l_rdata)
    );

    // stage 2: table data is back, form the result words
    logic r_s2_vld;
    t_s2  r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= n_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2 <= n_s2;
        end
    end

    always_comb begin
        logic [15:0] uval;
        logic [15:0] lc;

        uval = (r_s2.miss || (l2u_rdata == 16'h0000)) ? CH_QMARK : l2u_rdata;
        lc   = r_s2.miss ? CH_QMARK : u2l_rdata;

        o_push.n    = 2'd0;
        o_push.res0 = '{value: r_s2.lit0, last: 1'b1};
        o_push.res1 = '{value: r_s2.lit1, last: 1'b1};
        case (r_s2.op)
            OP_LIT1: begin
                o_push.n = 2'd1;
            end
            OP_LIT2: begin
                o_push.n         = 2'd2;
                o_push.res0.last = 1'b0;
            end
            OP_L2U: begin
                o_push.n          = 2'd1;
                o_push.res0.value = uval;
            end
            OP_L2U_TERM: begin
                o_push.n          = 2'd2;
                o_push.res0.value = uval;
                o_push.res0.last  = 1'b0;
                o_push.res1.value = 16'h0000;
            end
            OP_U2L: begin
                o_push.res0.value = lc & BYTE_MAX;
                if ((lc & HIGH_MASK) != 16'h0000) begin
                    o_push.n          = 2'd2;
                    o_push.res0.last  = 1'b0;
                    o_push.res1.value = {8'h00, lc[15:8]};
                end else begin
                    o_push.n = 2'd1;
                end
            end
            default: begin
                o_push.n = 2'd0;
            end
        endcase
        if (!r_s2_vld) begin
            o_push.n = 2'd0;
        end
    end

    assign o_stat.s1_vld = r_s1_vld;
    assign o_stat.s2_vld = r_s2_vld;

endmodule

// ===== rtl/dbcs_ofifo.sv =====
// dbcs_ofifo: result queue taking up to two words a cycle, giving one unless stalled.
// Depends on dbcs_pkg.

module dbcs_ofifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dbcs_pkg::t_push           i_push,
    input  logic                      i_stall,
    output logic                      o_valid,
    output dbcs_pkg::t_res            o_res,
    output logic [dbcs_pkg::FIFO_AW:0] o_count
);

    import dbcs_pkg::*;

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wp + FIFO_AW'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + FIFO_AW'(i_push.n);
            r_rp  <= r_rp + FIFO_AW'(pop);
            r_cnt <= r_cnt + (FIFO_AW + 1)'(i_push.n) - (FIFO_AW + 1)'(pop);
        end
    end

endmodule

// ===== rtl/dbcs_codepage_unicode_converter.sv =====
// Code page <-> Unicode converter. The first result word passes the table read and
// the result queue before it is offered.
// Throughput: one item per cycle for loads and single-word results while the result
// port is not stalled; pairs are paced by the single result port draining the queue.
// Reset: synchronous, clears pipeline valids, held lead byte, queue and config
// registers; the code and flag tables are not cleared and must be loaded first.

module dbcs_codepage_unicode_converter #(
    parameter int L2U_DEPTH = 65536,
    parameter int U2L_DEPTH = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dbcs_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [dbcs_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_req_type,
    input  logic [15:0]                 i_table_index,
    input  logic [15:0]                 i_data_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [15:0]                 o_out_value,
    output logic                        o_last
);

    import dbcs_pkg::*;

    t_cfg             r_cfg;
    t_push            push;
    t_stat            stat;
    t_res             res;
    logic [FIFO_AW:0] count;
    logic [FIFO_AW+1:0] need;
    logic             acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_L2U_SIZE:      r_cfg.l2u_size      <= i_cfg_data;
                CFG_U2L_SIZE:      r_cfg.u2l_size      <= i_cfg_data;
                CFG_L2U_PRESENT:   r_cfg.l2u_present   <= i_cfg_data[0];
                CFG_U2L_PRESENT:   r_cfg.u2l_present   <= i_cfg_data[0];
                CFG_FLAGS_PRESENT: r_cfg.flags_present <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // reserve two queue slots for every item in flight plus the new one
    assign need = (FIFO_AW + 2)'(2) * ((FIFO_AW + 2)'(stat.s1_vld) +
                  (FIFO_AW + 2)'(stat.s2_vld) + (FIFO_AW + 2)'(1));
    assign o_in_stall = ((FIFO_AW + 2)'(count) + need) > (FIFO_AW + 2)'(FIFO_DEPTH);
    assign acc = i_in_valid && !o_in_stall;

    dbcs_core #(.L2U_DEPTH(L2U_DEPTH), .U2L_DEPTH(U2L_DEPTH)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_acc        (acc),
        .i_req_type   (i_req_type),
        .i_table_index(i_table_index),
        .i_data_word  (i_data_word),
        .o_push       (push),
        .o_stat       (stat)
    );

    dbcs_ofifo u_ofifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_stall(i_out_stall),
        .o_valid(o_out_valid),
        .o_res  (res),
        .o_count(count)
    );

    assign o_out_value = res.value;
    assign o_last      = res.last;

endmodule

// ===== rtl/dbcs_chk.sv =====
// dbcs_chk: port-level checks for the converter, bound to the top level.
// Depends only on the top level's clock, reset, handshake and result ports.

module dbcs_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [15:0]                 o_out_value,
    input logic                        o_last
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_out_value) && $stable(o_last)))
        else $error("result word changed while stalled");

    // both words of a pair are queued together, so the second follows at once
    a_pair_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> o_out_valid)
        else $error("second word of a pair not ready");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind dbcs_codepage_unicode_converter dbcs_chk u_chk (.*);

// ===== tb/sv/tb_dbcs_codepage_unicode_converter.sv =====
// tb_dbcs_codepage_unicode_converter: self-checking bench for the code page converter.
// Depends on dbcs_pkg and dbcs_codepage_unicode_converter; keeps its own copy of the
// tables and settings, predicts every result word and checks the output stream in order.

module tb_dbcs_codepage_unicode_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import dbcs_pkg::*;

    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 85;
    localparam int MAX_REPORTS  = 100;

    // one line of the directed list: a register write or an input word
    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  kind;
        logic [15:0] idx;
        logic [15:0] data;
        logic        typed;
        logic [1:0]  n;
        logic [15:0] v0;
        logic [15:0] v1;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]   i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [2:0]          i_req_type = '0;
    logic [15:0]         i_table_index = '0;
    logic [15:0]         i_data_word = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [15:0]         o_out_value;
    logic                o_last;

    dbcs_codepage_unicode_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_table_index (i_table_index),
        .i_data_word   (i_data_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_value   (o_out_value),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mirror of the block's tables, settings and held lead byte
    logic [15:0] l2u_map [0:65535];
    logic [15:0] u2l_map [0:65535];
    logic        sb_flag [0:255];
    bit          l2u_set [0:65535];
    bit          u2l_set [0:65535];
    bit          flag_set [0:255];
    logic [7:0]  lead_byte = 8'h00;
    logic        lead_held = 1'b0;
    t_cfg        cfg_now = '0;

    t_res        due_words[$];
    t_row        dir_rows[$];
    int          fail_count = 0;
    int          gap_pct = 24;
    int          idle_cycles = 0;

    function automatic t_row item_row(input logic [2:0] kind, input logic [15:0] idx,
                                      input logic [15:0] data);
        t_row r;
        r = '0;
        r.kind = kind;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row typed_row(input logic [2:0] kind, input logic [15:0] idx,
                                       input logic [15:0] data, input logic [1:0] n,
                                       input logic [15:0] v0, input logic [15:0] v1);
        t_row r;
        r = item_row(kind, idx, data);
        r.typed = 1'b1;
        r.n = n;
        r.v0 = v0;
        r.v1 = v1;
        return r;
    endfunction

    function automatic t_row cfg_row(input t_cfg_idx ri, input logic [15:0] val);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.kind = ri;
        r.data = val;
        return r;
    endfunction

    function automatic logic [15:0] l2u_read(input logic [15:0] code);
        if (code >= cfg_now.l2u_size || l2u_map[code] == 16'h0000) begin
            return CH_QMARK;
        end
        return l2u_map[code];
    endfunction

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(7))
            0: return 16'h0000;
            1, 2, 3: return {8'h00, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(6))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h0100;
            3: return 16'h0300;
            4: return 16'h8000;
            5: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_byte();
        logic [7:0] b;
        // lean on one range so lead bytes and their flags come back often
        if ($urandom_range(9) < 4) begin
            b = 8'($urandom_range(8'h80, 8'h9F));
        end else begin
            b = 8'($urandom_range(1, 255));
        end
        return {8'($urandom), b};
    endfunction

    function automatic logic [15:0] rand_char();
        int r;
        r = $urandom_range(9);
        if (r < 5) begin
            return 16'($urandom_range(1, 16'h02FF));
        end else if (r < 7) begin
            return 16'($urandom_range(16'h0018, 16'h0120));
        end
        return 16'($urandom_range(1, 16'hFFFF));
    endfunction

    // advance the mirror by one accepted word and return the result words it causes
    task automatic convert_word(input t_row r, output int cnt, output logic [15:0] w0,
                                output logic [15:0] w1);
        logic [15:0] w [2];
        logic [15:0] lc;
        logic [7:0]  b;
        logic        tbl;
        cnt = 0;
        w[0] = 16'h0000;
        w[1] = 16'h0000;
        b = r.data[7:0];
        tbl = cfg_now.l2u_present && cfg_now.flags_present;
        case (r.kind)
            REQ_LOAD_L2U: begin
                l2u_map[r.idx] = r.data;
                l2u_set[r.idx] = 1'b1;
            end
            REQ_LOAD_U2L: begin
                u2l_map[r.idx] = r.data;
                u2l_set[r.idx] = 1'b1;
            end
            REQ_LOAD_FLAG: begin
                if (r.idx < FLAG_DEPTH) begin
                    sb_flag[r.idx[7:0]] = (r.data != 16'h0000);
                    flag_set[r.idx[7:0]] = 1'b1;
                end
            end
            REQ_LOCAL: begin
                if (b == 8'h00) begin
                    // flush a held lead alone, then terminate
                    if (lead_held) begin
                        w[cnt] = tbl ? l2u_read({8'h00, lead_byte}) : {8'h00, lead_byte};
                        cnt++;
                    end
                    w[cnt] = 16'h0000;
                    cnt++;
                    lead_held = 1'b0;
                    lead_byte = 8'h00;
                end else if (!tbl) begin
                    if (lead_held) begin
                        w[cnt] = {8'h00, lead_byte};
                        cnt++;
                    end
                    w[cnt] = {8'h00, b};
                    cnt++;
                    lead_held = 1'b0;
                    lead_byte = 8'h00;
                end else if (lead_held) begin
                    w[cnt] = l2u_read({lead_byte, b});
                    cnt++;
                    lead_held = 1'b0;
                    lead_byte = 8'h00;
                end else if (!sb_flag[b]) begin
                    lead_byte = b;
                    lead_held = 1'b1;
                end else begin
                    w[cnt] = l2u_read({8'h00, b});
                    cnt++;
                end
            end
            REQ_UNI: begin
                cnt = 1;
                if (r.data == 16'h0000) begin
                    w[0] = 16'h0000;
                end else if (!(cfg_now.u2l_present && cfg_now.flags_present)) begin
                    w[0] = (r.data >= CH_SPACE && r.data <= BYTE_MAX) ? r.data : CH_UNDERSCORE;
                end else begin
                    lc = (r.data < cfg_now.u2l_size) ? u2l_map[r.data] : CH_QMARK;
                    w[0] = {8'h00, lc[7:0]};
                    if ((lc & HIGH_MASK) != 16'h0000) begin
                        w[1] = {8'h00, lc[15:8]};
                        cnt = 2;
                    end
                end
            end
            default: ;
        endcase
        w0 = w[0];
        w1 = w[1];
    endtask

    task automatic drive_word(input t_row r);
        int          cnt;
        logic [15:0] w0;
        logic [15:0] w1;
        t_res        word;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_req_type = r.kind;
        i_table_index = r.idx;
        i_data_word = r.data;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        convert_word(r, cnt, w0, w1);
        if (r.typed) begin
            cnt = r.n;
            w0 = r.v0;
            w1 = r.v1;
        end
        for (int k = 0; k < cnt; k++) begin
            word.value = (k == 0) ? w0 : w1;
            word.last = (k == cnt - 1);
            due_words.push_back(word);
        end
        @(negedge i_clk);
    endtask

    // load any table entry or flag the next word would read before it was written
    task automatic prime_tables(input t_row r);
        logic [7:0]  b;
        logic [15:0] code;
        logic        want;
        want = 1'b0;
        code = 16'h0000;
        b = r.data[7:0];
        if (r.kind == REQ_LOCAL) begin
            if (!flag_set[b]) begin
                drive_word(item_row(REQ_LOAD_FLAG, {8'h00, b},
                                    $urandom_range(1) ? 16'($urandom) : 16'h0000));
            end
            if (cfg_now.l2u_present && cfg_now.flags_present) begin
                if (lead_held) begin
                    want = 1'b1;
                    code = (b == 8'h00) ? {8'h00, lead_byte} : {lead_byte, b};
                end else if (b != 8'h00 && sb_flag[b]) begin
                    want = 1'b1;
                    code = {8'h00, b};
                end
            end
            if (want && code < cfg_now.l2u_size && !l2u_set[code]) begin
                drive_word(item_row(REQ_LOAD_L2U, code, rand_entry()));
            end
        end else if (r.kind == REQ_UNI) begin
            if (cfg_now.u2l_present && cfg_now.flags_present && r.data != 16'h0000 &&
                r.data < cfg_now.u2l_size && !u2l_set[r.data]) begin
                drive_word(item_row(REQ_LOAD_U2L, r.data, rand_entry()));
            end
        end
    endtask

    task automatic send_word(input t_row r);
        prime_tables(r);
        drive_word(r);
    endtask

    // write a register once the block has drained
    task automatic write_reg(input t_cfg_idx ri, input logic [15:0] val);
        i_in_valid = 1'b0;
        while (due_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = ri;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (ri)
            CFG_L2U_SIZE:      cfg_now.l2u_size = val;
            CFG_U2L_SIZE:      cfg_now.u2l_size = val;
            CFG_L2U_PRESENT:   cfg_now.l2u_present = val[0];
            CFG_U2L_PRESENT:   cfg_now.u2l_present = val[0];
            CFG_FLAGS_PRESENT: cfg_now.flags_present = val[0];
            default: ;
        endcase
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < gap_pct);
    end

    always @(posedge i_clk) begin : check_words
        t_res want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (due_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $error("result word with none expected: out_value %h last %b",
                           o_out_value, o_last);
                end
            end else begin
                want = due_words.pop_front();
                if (o_out_value !== want.value) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $error("out_value: expected %h, got %h", want.value, o_out_value);
                    end
                end
                if (o_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $error("last: expected %b, got %b", want.last, o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int          k;
        int          len;
        int          sel;
        logic        uni;
        logic [2:0]  kind;
        logic [15:0] sz_l2u;
        logic [15:0] sz_u2l;
        logic [2:0]  on;

        // fallback right after reset
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'h0000, 16'h00FF, 1, 16'h00FF, 16'h0000));
        // only the low byte counts, so this one terminates
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'hFFFF, 16'hAB00, 1, 16'h0000, 16'h0000));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'h001F, 1, CH_UNDERSCORE, 16'h0000));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'h00FF, 1, 16'h00FF, 16'h0000));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'h0100, 1, CH_UNDERSCORE, 16'h0000));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'hFFFF, 1, CH_UNDERSCORE, 16'h0000));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000));
        dir_rows.push_back(typed_row(REQ_SPARE_LAST, 16'hFFFF, 16'hFFFF, 0, 16'h0000,
                                     16'h0000));
        // table mode
        dir_rows.push_back(cfg_row(CFG_L2U_SIZE, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_U2L_SIZE, 16'h0100));
        dir_rows.push_back(cfg_row(CFG_L2U_PRESENT, 16'h0001));
        dir_rows.push_back(cfg_row(CFG_U2L_PRESENT, 16'h0001));
        dir_rows.push_back(cfg_row(CFG_FLAGS_PRESENT, 16'h0001));
        dir_rows.push_back(item_row(REQ_LOAD_FLAG, 16'h0041, 16'h0001));
        dir_rows.push_back(item_row(REQ_LOAD_FLAG, 16'h0081, 16'h0000));
        // out of range flag load must not alias onto entry 0x81
        dir_rows.push_back(item_row(REQ_LOAD_FLAG, 16'h0181, 16'h0001));
        dir_rows.push_back(item_row(REQ_LOAD_L2U, 16'h0041, 16'h3042));
        dir_rows.push_back(item_row(REQ_LOAD_L2U, 16'h8141, 16'h4E00));
        dir_rows.push_back(item_row(REQ_LOAD_L2U, 16'h0081, 16'h0000));
        dir_rows.push_back(item_row(REQ_LOAD_U2L, 16'h0041, 16'h8140));
        dir_rows.push_back(item_row(REQ_LOAD_U2L, 16'h0042, 16'h0000));
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'h0000, 16'h0041, 1, 16'h3042, 16'h0000));
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'h0000, 16'h0081, 0, 16'h0000, 16'h0000));
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'h0000, 16'h0041, 1, 16'h4E00, 16'h0000));
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'h0000, 16'h0081, 0, 16'h0000, 16'h0000));
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'h0000, 16'h0000, 2, CH_QMARK, 16'h0000));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'h0041, 2, 16'h0040, 16'h0081));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'h0042, 1, 16'h0000, 16'h0000));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'h0100, 1, CH_QMARK, 16'h0000));
        dir_rows.push_back(typed_row(REQ_UNI, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000));
        // lead held while table mode goes away
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'h0000, 16'h0081, 0, 16'h0000, 16'h0000));
        dir_rows.push_back(cfg_row(CFG_FLAGS_PRESENT, 16'h0000));
        dir_rows.push_back(typed_row(REQ_LOCAL, 16'h0000, 16'h0042, 2, 16'h0081, 16'h0042));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_reg(t_cfg_idx'(dir_rows[i].kind), dir_rows[i].data);
            end else begin
                send_word(dir_rows[i]);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            gap_pct = (p == 4) ? 0 : 24;
            if (p == 0) begin
                sz_l2u = 16'hFFFF;
                sz_u2l = 16'hFFFF;
                on = 3'b111;
            end else if (p == 1) begin
                sz_l2u = 16'h0000;
                sz_u2l = 16'h0000;
                on = 3'b000;
            end else if (p == 2) begin
                sz_l2u = 16'h0000;
                sz_u2l = 16'h0000;
                on = 3'b111;
            end else begin
                sz_l2u = pick_size();
                sz_u2l = pick_size();
                on = {$urandom_range(9) < 7, $urandom_range(9) < 7, $urandom_range(9) < 7};
            end
            write_reg(CFG_L2U_SIZE, sz_l2u);
            write_reg(CFG_U2L_SIZE, sz_u2l);
            write_reg(CFG_L2U_PRESENT, {15'h0000, on[2]});
            write_reg(CFG_U2L_PRESENT, {15'h0000, on[1]});
            write_reg(CFG_FLAGS_PRESENT, {15'h0000, on[0]});

            k = 0;
            while (k < PHASE_ITEMS) begin
                sel = $urandom_range(99);
                if (sel < 8) begin
                    kind = 3'($urandom_range(REQ_LOAD_L2U, REQ_LOAD_FLAG));
                    send_word(item_row(kind, $urandom_range(1) ? 16'($urandom)
                                                               : 16'($urandom_range(255)),
                                       rand_entry()));
                    k++;
                end else if (sel < 11) begin
                    kind = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
                    send_word(item_row(kind, 16'($urandom), 16'($urandom)));
                end else begin
                    // one string; now and then leave it unterminated
                    uni = $urandom_range(1);
                    kind = uni ? REQ_UNI : REQ_LOCAL;
                    len = $urandom_range(1, 12);
                    for (int j = 0; j < len; j++) begin
                        send_word(item_row(kind, 16'($urandom), uni ? rand_char() : rand_byte()));
                        k++;
                    end
                    if ($urandom_range(9) != 0) begin
                        send_word(item_row(kind, 16'($urandom),
                                           uni ? 16'h0000 : {8'($urandom), 8'h00}));
                        k++;
                    end
                end
            end
        end

        i_in_valid = 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dbcs_pkg.sv
rtl/dbcs_ram.sv
rtl/dbcs_core.sv
rtl/dbcs_ofifo.sv
rtl/dbcs_codepage_unicode_converter.sv
rtl/dbcs_chk.sv
tb/sv/tb_dbcs_codepage_unicode_converter.sv
